### src/pekc_pkg.sv
// ----------------------------------------------------------------------------
// pekc_pkg
// Shared types and codes for the keypad PIN-entry controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pekc_pkg;

    // Default PIN length
    localparam int PIN_LEN_DEF = 4;

    // Packed PIN shown on the result: four bits per digit, last four digits
    localparam int PIN_W = 16;

    // Command codes
    localparam logic [2:0] CMD_KEY   = 3'd0;
    localparam logic [2:0] CMD_STATE = 3'd1;
    localparam logic [2:0] CMD_POLL  = 3'd2;
    localparam logic [2:0] CMD_GET   = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;
    localparam logic [2:0] CMD_ERROR = 3'd5;
    localparam logic [2:0] CMD_TICK  = 3'd6;

    // Key codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_MODE_A    = 4'd10;
    localparam logic [3:0] KEY_MODE_D    = 4'd13;
    localparam logic [3:0] KEY_STAR      = 4'd14;
    localparam logic [3:0] KEY_HASH      = 4'd15;

    // Reply kinds
    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_POLL = 2'd1;
    localparam logic [1:0] RESP_DATA = 2'd2;

    // Done messages
    localparam logic [1:0] MSG_NONE      = 2'd0;
    localparam logic [1:0] MSG_OK        = 2'd1;
    localparam logic [1:0] MSG_WRONG_PIN = 2'd2;
    localparam logic [1:0] MSG_ERROR     = 2'd3;

    // Configuration register indexes and reset values
    localparam logic CFG_UNIT_ID      = 1'b0;
    localparam logic CFG_DONE_TIMEOUT = 1'b1;
    localparam int   CFG_DATA_W       = 16;

    localparam logic [7:0]  UNIT_ID_RST      = 8'd1;
    localparam logic [15:0] DONE_TIMEOUT_RST = 16'd3000;

    // Input word
    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] key_code;
        logic [7:0] target_id;
        logic       armed_in;
        logic       wrong_pin;
    } t_in;

    // Result word
    typedef struct packed {
        logic [1:0]       response_kind;
        logic             ready_res;
        logic [PIN_W-1:0] pin_value;
        logic [2:0]       mode_key;
        logic [2:0]       digits_entered;
        logic [1:0]       done_message;
        logic             armed;
    } t_out;

endpackage

`default_nettype wire

### src/pekc_core.sv
// ----------------------------------------------------------------------------
// pekc_core
// Entry state, armed flag, done message and timer. Updates the state for one
// accepted word and forms the result word from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module pekc_core
    import pekc_pkg::*;
#(
    parameter int PIN_LEN = PIN_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire t_in                   i_in,
    output t_out                       o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(PIN_LEN + 1);

    logic [7:0]       r_unit_id;
    logic [15:0]      r_timeout;
    logic [PIN_W-1:0] r_pin,   n_pin;
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_mode,  n_mode;
    logic             r_ready, n_ready;
    logic             r_armed, n_armed;
    logic [1:0]       r_done,  n_done;
    logic [15:0]      r_timer, n_timer;
    logic [1:0]       resp;
    logic             mine;
    logic             full;
    logic [15:0]      timer_inc;

    assign mine      = (i_in.target_id == r_unit_id);
    assign timer_inc = (r_timer != 16'hFFFF) ? r_timer + 16'd1 : r_timer;

    // Next state for the word at the input
    always_comb begin
        n_pin   = r_pin;
        n_count = r_count;
        n_mode  = r_mode;
        n_ready = r_ready;
        n_armed = r_armed;
        n_done  = r_done;
        n_timer = r_timer;
        resp    = RESP_NONE;
        full    = 1'b0;
        case (i_in.cmd)
            CMD_KEY: begin
                if (i_in.key_code == KEY_STAR || r_done != MSG_NONE) begin
                    // star, or any key over a done message: drop entry and message
                    n_pin   = '0;
                    n_count = '0;
                    n_mode  = 3'd0;
                    n_ready = 1'b0;
                    n_done  = MSG_NONE;
                    n_timer = 16'd0;
                end
                full = (n_count == CNT_W'(PIN_LEN));
                if (i_in.key_code != KEY_STAR && !n_ready) begin
                    if (i_in.key_code inside {[4'd0:KEY_DIGIT_MAX]}) begin
                        if (!full) begin
                            n_pin   = {n_pin[PIN_W-5:0], i_in.key_code};
                            n_count = n_count + CNT_W'(1);
                        end
                    end else if (i_in.key_code inside {[KEY_MODE_A:KEY_MODE_D]}) begin
                        if (full) begin
                            n_mode  = 3'(i_in.key_code - KEY_DIGIT_MAX);
                            n_ready = 1'b1;
                        end
                    end else if (i_in.key_code == KEY_HASH) begin
                        if (full && (n_mode != 3'd0 || r_armed)) begin
                            n_ready = 1'b1;
                        end
                    end
                end
            end
            CMD_STATE: begin
                n_armed = i_in.armed_in;
            end
            CMD_POLL: begin
                if (mine) begin
                    resp = RESP_POLL;
                end
            end
            CMD_GET: begin
                if (mine && r_ready) begin
                    resp = RESP_DATA;
                end
            end
            CMD_ACK, CMD_ERROR: begin
                if (mine) begin
                    n_pin   = '0;
                    n_count = '0;
                    n_mode  = 3'd0;
                    n_ready = 1'b0;
                    n_timer = 16'd0;
                    if (i_in.cmd == CMD_ACK) begin
                        n_done = MSG_OK;
                    end else begin
                        n_done = i_in.wrong_pin ? MSG_WRONG_PIN : MSG_ERROR;
                    end
                end
            end
            CMD_TICK: begin
                // age the message, clear it once the timeout is reached
                if (r_done != MSG_NONE) begin
                    if (timer_inc >= r_timeout) begin
                        n_done  = MSG_NONE;
                        n_timer = 16'd0;
                    end else begin
                        n_timer = timer_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Form the result word from the updated state
    always_comb begin
        o_res.response_kind  = resp;
        o_res.ready_res      = n_ready;
        o_res.pin_value      = n_pin;
        o_res.mode_key       = n_mode;
        o_res.digits_entered = (32'(n_count) > 32'd7) ? 3'd7 : 3'(32'(n_count));
        o_res.done_message   = n_done;
        o_res.armed          = n_armed;
    end

    // Advance state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin   <= '0;
            r_count <= '0;
            r_mode  <= 3'd0;
            r_ready <= 1'b0;
            r_armed <= 1'b0;
            r_done  <= MSG_NONE;
            r_timer <= 16'd0;
        end else if (i_accept) begin
            r_pin   <= n_pin;
            r_count <= n_count;
            r_mode  <= n_mode;
            r_ready <= n_ready;
            r_armed <= n_armed;
            r_done  <= n_done;
            r_timer <= n_timer;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_id <= UNIT_ID_RST;
            r_timeout <= DONE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_UNIT_ID) begin
                r_unit_id <= i_cfg_data[7:0];
            end else begin
                r_timeout <= i_cfg_data[15:0];
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= PIN_LEN)
        else $error("digit count beyond PIN length");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_count == CNT_W'(PIN_LEN)))
        else $error("entry ready without a full PIN");

    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done == MSG_NONE) |-> (r_timer == 16'd0))
        else $error("done timer running without a message");

    a_mode_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != 3'd0) |-> r_ready)
        else $error("mode set on an entry that is not ready");

endmodule

`default_nettype wire

### src/pekc_obuf.sv
// ----------------------------------------------------------------------------
// pekc_obuf
// Output register with a skid stage: takes a result word while the previous
// one still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module pekc_obuf
    import pekc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_out i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_out      o_data,
    input  wire logic i_ready
);

    logic r_out_vld,  n_out_vld;
    logic r_skid_vld, n_skid_vld;
    t_out r_out,      n_out;
    t_out r_skid,     n_skid;

    assign o_ready = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Drain first, then place the pushed word in the first free slot
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (r_out_vld && i_ready) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_out_vld) begin
                n_out     = i_data;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = i_data;
                n_skid_vld = 1'b1;
            end
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_push)
        else $error("word pushed into a full buffer");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid word lost under stall");

endmodule

`default_nettype wire

### src/pin_entry_keypad_controller.sv
// ----------------------------------------------------------------------------
// pin_entry_keypad_controller
// Keypad PIN-entry controller: collects digits and a mode key, answers the
// master's poll and get commands, shows ok/error messages and ages them.
// ----------------------------------------------------------------------------
//
//  channel   ports                                      direction
//  -------   -----------------------------------------  ---------
//  input     i_in_valid / o_in_ready / i_in_data        in
//  result    o_out_valid / i_out_ready / o_out_data     out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data          in
//
//  One word per cycle while o_in_ready is high: the entry state loads at the
//  edge a word is accepted; its result is offered from the next cycle if the
//  output register is free, else held in the skid stage. These two slots let
//  input continue under a stall; o_in_ready drops only when both are full.
//  Synchronous active-low reset clears the entry, armed flag and message and
//  loads unit_id = 1, done_timeout = 3000.
// ----------------------------------------------------------------------------
`default_nettype none

module pin_entry_keypad_controller
    import pekc_pkg::*;
#(
    parameter int PIN_LEN = PIN_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic accept;
    t_out res;

    assign accept = i_in_valid && o_in_ready;

    // Entry state and result formation
    pekc_core #(
        .PIN_LEN (PIN_LEN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in_data),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Result buffer
    pekc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (res),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready)
    );

endmodule

`default_nettype wire
